FILE: src/lca_binary_lifting_macros.svh
// Assertion macros for the LCA binary-lifting block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LCA_BINARY_LIFTING_MACROS_SVH
`define LCA_BINARY_LIFTING_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LCAB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LCAB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCAB_ASSERT_IMP(lbl, ante, cons, msg)
`define LCAB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/lcab_pkg.sv
// Shared types and codes for the LCA binary-lifting block.
// No dependencies.
`default_nettype none
package lcab_pkg;
    localparam int ID_W   = 10;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
        logic root_ok;
    } id_ok_t;
endpackage
`default_nettype wire

FILE: src/lcab_id_check.sv
// Range check of the two command node ids and the root register.
// Depends on lcab_pkg.
`default_nettype none
module lcab_id_check #(
    parameter int MAX_NODES = 1023
) (
    input  wire logic [lcab_pkg::ID_W-1:0] node_a,
    input  wire logic [lcab_pkg::ID_W-1:0] node_b,
    input  wire logic [lcab_pkg::ID_W-1:0] root,
    output lcab_pkg::id_ok_t               ok
);
    // valid ids are 1..MAX_NODES
    always_comb
    begin
        ok.a_ok    = (node_a != '0) && (node_a <= MAX_NODES);
        ok.b_ok    = (node_b != '0) && (node_b <= MAX_NODES);
        ok.root_ok = (root != '0) && (root <= MAX_NODES);
    end
endmodule
`default_nettype wire

FILE: src/lca_binary_lifting.sv
// Top level: LCA by binary lifting over an adjacency-list tree store.
// Depends on lcab_pkg, lcab_id_check and lca_binary_lifting_macros.svh.
//
//   channel  | signals                          | handshake
//   ---------+----------------------------------+-----------------------------
//   command  | cmd, node_a, node_b              | start & !busy
//   result   | result_kind, status, ancestor    | done, one cycle, no stall
//   config   | cfg_data (root_node)             | cfg_we
//
// Build clears the node depths, writes the root's ancestor row, then walks
// the tree breadth-first from the root, filling the row of each reached node.
// Add and query with an out-of-range node id answer from idle with ST_RANGE.
// A build with an out-of-range root answers ST_RANGE after its clearing pass.
// After reset a clearing pass zeroes the list heads and depths; busy is high
// meanwhile. Results cannot be stalled.
`default_nettype none
`include "lca_binary_lifting_macros.svh"
module lca_binary_lifting #(
    parameter int MAX_NODES   = 1023,
    parameter int LIFT_LEVELS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lcab_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lcab_pkg::ID_W-1:0]     node_a,
    input  wire logic [lcab_pkg::ID_W-1:0]     node_b,
    input  wire logic                          cfg_we,
    input  wire logic [lcab_pkg::ID_W-1:0]     cfg_data,
    output logic                               done,
    output logic [lcab_pkg::CMD_W-1:0]         result_kind,
    output logic [lcab_pkg::STAT_W-1:0]        status,
    output logic [lcab_pkg::ID_W-1:0]          ancestor
);
    localparam int IDW   = lcab_pkg::ID_W;
    localparam int NW    = $clog2(MAX_NODES + 1);      // node id / depth width
    localparam int SLOTS = 2 * MAX_NODES;              // edge slots 1..SLOTS
    localparam int EW    = $clog2(SLOTS + 1);
    localparam int ROW   = LIFT_LEVELS + 1;
    localparam int LW    = $clog2(ROW);
    localparam int AW    = NW + LW;                    // {node, level}

    localparam logic [4:0] S_IDLE   = 5'd0,  S_CLEAR  = 5'd1,
                           S_ADD_A0 = 5'd2,  S_ADD_A1 = 5'd3,
                           S_ADD_B0 = 5'd4,  S_ADD_B1 = 5'd5,
                           S_B_INIT = 5'd6,  S_B_ROOT = 5'd7,
                           S_W_POP  = 5'd8,  S_W_CUR  = 5'd9,
                           S_W_HEAD = 5'd10, S_W_EDGE = 5'd11,
                           S_W_NB   = 5'd12, S_W_CHK  = 5'd13,
                           S_W_LIFT = 5'd14, S_W_LW   = 5'd15,
                           S_Q0     = 5'd16, S_Q1     = 5'd17,
                           S_Q2     = 5'd18, S_QL_R   = 5'd19,
                           S_QL_D   = 5'd20, S_QL_C   = 5'd21,
                           S_Q_EQ   = 5'd22, S_QB_R   = 5'd23,
                           S_QB_RX  = 5'd24, S_QB_C   = 5'd25,
                           S_QF_R   = 5'd26, S_QF     = 5'd27;

    // ---------------- registers ----------------
    logic [4:0]      state_reg,  state_next;
    logic [NW-1:0]   clr_reg,    clr_next;      // clearing pass index
    logic            clr_bld_reg, clr_bld_next; // pass is part of a build
    logic [EW-1:0]   ec_reg,     ec_next;       // edge count
    logic [NW-1:0]   x_reg,      x_next;
    logic [NW-1:0]   y_reg,      y_next;
    logic [NW-1:0]   dx_reg,     dx_next;
    logic [NW-1:0]   cur_reg,    cur_next;
    logic [NW-1:0]   cdep_reg,   cdep_next;
    logic [EW-1:0]   e_reg,      e_next;
    logic [NW-1:0]   nb_reg,     nb_next;
    logic [NW-1:0]   m_reg,      m_next;
    logic [NW-1:0]   u_reg,      u_next;
    logic [LW-1:0]   lvl_reg,    lvl_next;
    logic [NW-1:0]   hp_reg,     hp_next;       // walk queue head
    logic [NW-1:0]   tl_reg,     tl_next;       // walk queue tail
    logic [IDW-1:0]  root_reg;
    logic            done_reg,   done_next;
    logic [lcab_pkg::CMD_W-1:0]  kind_reg, kind_next;
    logic [lcab_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [NW-1:0]   anc_reg,    anc_next;

    // ---------------- memories ----------------
    logic [EW-1:0] head_mem [0:MAX_NODES];
    logic [NW-1:0] tgt_mem  [0:SLOTS];
    logic [EW-1:0] nxt_mem  [0:SLOTS];
    logic [NW-1:0] dep_mem  [0:MAX_NODES];
    logic [NW-1:0] anc_mem  [0:(2**AW)-1];
    logic [NW-1:0] q_mem    [0:MAX_NODES];

    logic          head_we;  logic [NW-1:0] head_wa, head_ra; logic [EW-1:0] head_wd, head_rd;
    logic          edge_we;  logic [EW-1:0] edge_wa, edge_ra;
    logic [NW-1:0] tgt_wd, tgt_rd;   logic [EW-1:0] nxt_wd, nxt_rd;
    logic          dep_we;   logic [NW-1:0] dep_wa, dep_ra, dep_wd, dep_rd;
    logic          anc_we;   logic [AW-1:0] anc_wa, anc_ra; logic [NW-1:0] anc_wd, anc_rd;
    logic          q_we;     logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            tgt_mem[edge_wa] <= tgt_wd;
            nxt_mem[edge_wa] <= nxt_wd;
        end
        tgt_rd <= tgt_mem[edge_ra];
        nxt_rd <= nxt_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_wa] <= dep_wd;
        end
        dep_rd <= dep_mem[dep_ra];
    end

    // rows are written whole when a node is reached, so no clearing needed
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wa] <= anc_wd;
        end
        anc_rd <= anc_mem[anc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd <= q_mem[q_ra];
    end

    // ---------------- id checks ----------------
    lcab_pkg::id_ok_t ok;

    lcab_id_check #(
        .MAX_NODES (MAX_NODES)
    ) u_id_check (
        .node_a (node_a),
        .node_b (node_b),
        .root   (root_reg),
        .ok     (ok)
    );

    logic [NW-1:0]   root_n;
    logic [EW:0]     ec_plus2;
    logic [EW-1:0]   ec_inc;
    logic [NW-1:0]   lift_val;

    assign root_n   = NW'(root_reg);
    assign ec_plus2 = {1'b0, ec_reg} + (EW+1)'(2);
    assign ec_inc   = ec_reg + EW'(1);
    assign lift_val = (m_reg == '0) ? '0 : anc_rd;   // node 0 has no ancestors
    assign busy     = (state_reg != S_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        clr_bld_next = clr_bld_reg;
        ec_next      = ec_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dx_next      = dx_reg;
        cur_next     = cur_reg;
        cdep_next    = cdep_reg;
        e_next       = e_reg;
        nb_next      = nb_reg;
        m_next       = m_reg;
        u_next       = u_reg;
        lvl_next     = lvl_reg;
        hp_next      = hp_reg;
        tl_next      = tl_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        stat_next    = stat_reg;
        anc_next     = anc_reg;

        head_we = 1'b0; head_wa = x_reg; head_wd = ec_inc; head_ra = x_reg;
        edge_we = 1'b0; edge_wa = ec_inc; tgt_wd = y_reg; nxt_wd = head_rd;
        edge_ra = e_reg;
        dep_we  = 1'b0; dep_wa = nb_reg; dep_wd = cdep_reg + NW'(1); dep_ra = x_reg;
        anc_we  = 1'b0; anc_wa = {nb_reg, lvl_reg}; anc_wd = lift_val;
        anc_ra  = {y_reg, lvl_reg};
        q_we    = 1'b0; q_wa = tl_reg; q_wd = nb_reg; q_ra = hp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next    = NW'(node_a);
                    y_next    = NW'(node_b);
                    kind_next = cmd;
                    stat_next = lcab_pkg::ST_OK;
                    anc_next  = '0;
                    priority if (cmd == lcab_pkg::CMD_ADD)
                    begin
                        if (!ok.a_ok || !ok.b_ok)
                        begin
                            stat_next = lcab_pkg::ST_RANGE;
                            done_next = 1'b1;
                        end
                        else if (ec_plus2 > (EW+1)'(SLOTS))
                        begin
                            stat_next = lcab_pkg::ST_FULL;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_ADD_A0;
                        end
                    end
                    else if (cmd == lcab_pkg::CMD_BUILD)
                    begin
                        clr_next     = '0;
                        clr_bld_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else if (cmd == lcab_pkg::CMD_QUERY)
                    begin
                        if (!ok.a_ok || !ok.b_ok)
                        begin
                            stat_next = lcab_pkg::ST_RANGE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_Q0;
                        end
                    end
                    else
                    begin
                        // unknown command: dropped silently
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                dep_we  = 1'b1;
                dep_wa  = clr_reg;
                dep_wd  = '0;
                head_we = !clr_bld_reg;   // list heads only after reset
                head_wa = clr_reg;
                head_wd = '0;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(MAX_NODES))
                begin
                    if (!clr_bld_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (ok.root_ok)
                    begin
                        state_next = S_B_INIT;
                    end
                    else
                    begin
                        stat_next  = lcab_pkg::ST_RANGE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            // ---- add edge: link a->b then b->a ----
            S_ADD_A0:
            begin
                head_ra    = x_reg;
                state_next = S_ADD_A1;
            end
            S_ADD_A1:
            begin
                edge_we    = 1'b1;
                tgt_wd     = y_reg;
                head_we    = 1'b1;
                head_wa    = x_reg;
                ec_next    = ec_inc;
                state_next = S_ADD_B0;
            end
            S_ADD_B0:
            begin
                head_ra    = y_reg;
                state_next = S_ADD_B1;
            end
            S_ADD_B1:
            begin
                edge_we    = 1'b1;
                tgt_wd     = x_reg;
                head_we    = 1'b1;
                head_wa    = y_reg;
                ec_next    = ec_inc;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            // ---- build ----
            S_B_INIT:
            begin
                dep_we     = 1'b1;
                dep_wa     = root_n;
                dep_wd     = NW'(1);
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = root_n;
                hp_next    = '0;
                tl_next    = NW'(1);
                lvl_next   = '0;
                state_next = S_B_ROOT;
            end
            S_B_ROOT:
            begin
                anc_we = 1'b1;
                anc_wa = {root_n, lvl_reg};
                anc_wd = '0;
                lvl_next = lvl_reg + LW'(1);
                if (lvl_reg == LW'(LIFT_LEVELS))
                begin
                    state_next = S_W_POP;
                end
            end
            S_W_POP:
            begin
                q_ra = hp_reg;
                if (hp_reg == tl_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    hp_next    = hp_reg + NW'(1);
                    state_next = S_W_CUR;
                end
            end
            S_W_CUR:
            begin
                cur_next   = q_rd;
                head_ra    = q_rd;
                dep_ra     = q_rd;
                state_next = S_W_HEAD;
            end
            S_W_HEAD:
            begin
                cdep_next  = dep_rd;
                e_next     = head_rd;
                state_next = S_W_EDGE;
            end
            S_W_EDGE:
            begin
                edge_ra = e_reg;
                if (e_reg == '0 || e_reg > ec_reg)
                begin
                    state_next = S_W_POP;
                end
                else
                begin
                    state_next = S_W_NB;
                end
            end
            S_W_NB:
            begin
                nb_next    = tgt_rd;
                e_next     = nxt_rd;
                dep_ra     = tgt_rd;
                state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (dep_rd != '0)
                begin
                    state_next = S_W_EDGE;   // already reached (parent, self loop)
                end
                else
                begin
                    dep_we   = 1'b1;
                    dep_wa   = nb_reg;
                    dep_wd   = cdep_reg + NW'(1);
                    anc_we   = 1'b1;
                    anc_wa   = {nb_reg, LW'(0)};
                    anc_wd   = cur_reg;
                    // tail stays within MAX_NODES: each node enters once
                    q_we     = 1'b1;
                    q_wa     = tl_reg;
                    q_wd     = nb_reg;
                    tl_next  = tl_reg + NW'(1);
                    m_next   = cur_reg;
                    lvl_next = LW'(1);
                    state_next = S_W_LIFT;
                end
            end
            S_W_LIFT:
            begin
                anc_ra     = {m_reg, lvl_reg - LW'(1)};
                state_next = S_W_LW;
            end
            S_W_LW:
            begin
                anc_we   = 1'b1;
                anc_wa   = {nb_reg, lvl_reg};
                anc_wd   = lift_val;
                m_next   = lift_val;
                lvl_next = lvl_reg + LW'(1);
                if (lvl_reg == LW'(LIFT_LEVELS))
                begin
                    state_next = S_W_EDGE;
                end
                else
                begin
                    state_next = S_W_LIFT;
                end
            end
            // ---- query ----
            S_Q0:
            begin
                dep_ra     = x_reg;
                state_next = S_Q1;
            end
            S_Q1:
            begin
                dx_next    = dep_rd;
                dep_ra     = y_reg;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                lvl_next = LW'(LIFT_LEVELS);
                if (dx_reg == '0 || dep_rd == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (dx_reg > dep_rd)
                    begin
                        x_next  = y_reg;
                        y_next  = x_reg;
                        dx_next = dep_rd;
                    end
                    state_next = S_QL_R;
                end
            end
            S_QL_R:
            begin
                anc_ra     = {y_reg, lvl_reg};
                state_next = S_QL_D;
            end
            S_QL_D:
            begin
                u_next     = anc_rd;
                dep_ra     = anc_rd;
                state_next = S_QL_C;
            end
            S_QL_C:
            begin
                if (dep_rd >= dx_reg)
                begin
                    y_next = u_reg;
                end
                lvl_next = lvl_reg - LW'(1);
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_EQ;
                end
                else
                begin
                    state_next = S_QL_R;
                end
            end
            S_Q_EQ:
            begin
                lvl_next = LW'(LIFT_LEVELS);
                if (x_reg == y_reg)
                begin
                    anc_next   = x_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_QB_R;
                end
            end
            S_QB_R:
            begin
                anc_ra     = {y_reg, lvl_reg};
                state_next = S_QB_RX;
            end
            S_QB_RX:
            begin
                u_next     = anc_rd;
                anc_ra     = {x_reg, lvl_reg};
                state_next = S_QB_C;
            end
            S_QB_C:
            begin
                if (u_reg != anc_rd)
                begin
                    y_next = u_reg;
                    x_next = anc_rd;
                end
                lvl_next = lvl_reg - LW'(1);
                if (lvl_reg == '0)
                begin
                    state_next = S_QF_R;
                end
                else
                begin
                    state_next = S_QB_R;
                end
            end
            S_QF_R:
            begin
                anc_ra     = {x_reg, LW'(0)};
                state_next = S_QF;
            end
            S_QF:
            begin
                anc_next   = anc_rd;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            clr_bld_reg <= 1'b0;
            ec_reg      <= '0;
            root_reg    <= IDW'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_bld_reg <= clr_bld_next;
            ec_reg      <= ec_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                root_reg <= cfg_data;
            end
        end
    end

    // datapath words, no reset
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        dx_reg   <= dx_next;
        cur_reg  <= cur_next;
        cdep_reg <= cdep_next;
        e_reg    <= e_next;
        nb_reg   <= nb_next;
        m_reg    <= m_next;
        u_reg    <= u_next;
        lvl_reg  <= lvl_next;
        hp_reg   <= hp_next;
        tl_reg   <= tl_next;
        kind_reg <= kind_next;
        stat_reg <= stat_next;
        anc_reg  <= anc_next;
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign status      = stat_reg;
    assign ancestor    = IDW'(anc_reg);

    // ---------------- assertions ----------------
    `LCAB_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while busy")
    `LCAB_ASSERT_NXT(a_build_busy, start && !busy && cmd == lcab_pkg::CMD_BUILD, busy, "build not started")
    `LCAB_ASSERT_IMP(a_ec_bound, 1'b1, ec_reg <= EW'(SLOTS), "edge count past slots")
    `LCAB_ASSERT_IMP(a_anc_zero, done_reg && kind_reg != lcab_pkg::CMD_QUERY, anc_reg == '0, "ancestor on non-query")
endmodule
`default_nettype wire
